FILE: sv/differential_drive_odometry_unit_assert.svh
// assertion macros for the odometry unit
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ODO_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("odometry check failed");
`define ODO_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("odometry check failed");
`else
`define ODO_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ODO_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/ddo_pkg.sv
// shared types and constants of the odometry unit
// no dependencies
package ddo_pkg;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_MPC = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_HPC = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_YPC = 2'd2;

    localparam logic [39:0] MPC_RESET = 40'd2417950;
    localparam logic [39:0] HPC_RESET = 40'd166975242;
    localparam logic [39:0] YPC_RESET = 40'd4098222;

    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [47:0] RATE_MAX = 48'h7FFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE, ST_COR, ST_MUL, ST_POS, ST_HEAD, ST_COR2, ST_DIV, ST_DIV2, ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input request
        logic cor_init; // seed cordic from old heading
        logic cor_step;
        logic mul_step;
        logic pos_upd;
        logic head_upd;
        logic cor2_init;
        logic div_init; // set up divide (sel 0 linear, 1 yaw)
        logic div_sel;
        logic div_step;
        logic div_fin;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic cor_last;
        logic mul_last;
        logic div_last;
        logic us_zero;
    } stat_t;

    function automatic logic signed [31:0] atan_val(input logic [4:0] i);
        logic signed [31:0] t;
        unique case (i)
            5'd0: t = 536870912;  5'd1: t = 316933406; 5'd2: t = 167458907;
            5'd3: t = 85004756;   5'd4: t = 42667331;  5'd5: t = 21354465;
            5'd6: t = 10679838;   5'd7: t = 5340245;   5'd8: t = 2670163;
            5'd9: t = 1335087;    5'd10: t = 667544;   5'd11: t = 333772;
            5'd12: t = 166886;    5'd13: t = 83443;    5'd14: t = 41722;
            5'd15: t = 20861;     5'd16: t = 10430;    5'd17: t = 5215;
            5'd18: t = 2608;      5'd19: t = 1304;     5'd20: t = 652;
            5'd21: t = 326;       5'd22: t = 163;      5'd23: t = 81;
            5'd24: t = 41;        5'd25: t = 20;       5'd26: t = 10;
            5'd27: t = 5;         5'd28: t = 3;        5'd29: t = 1;
            5'd30: t = 1;         default: t = 0;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/differential_drive_odometry_unit.sv
// top level of the differential drive odometry unit
// depends on ddo_pkg, ddo_ctrl, ddo_datapath and the assertion header
//
// usage:
//   s_ channel: one request carries left_count, right_count (signed counts
//   since the last request) and elapsed_us; s_ready is high only while the
//   unit is idle, so one request is in work at a time
//   m_ channel: one result per request with the new pose, heading, yaw
//   quaternion terms and rates; rate_valid is low when elapsed_us is zero
//   order of work: a cordic pass on the old heading, the serial multiply,
//   the position and heading updates, a cordic pass on half the new
//   heading, then the bit-serial linear and yaw rate divides; a new
//   request is taken only once the last result is in the output register;
//   the result sits in an output register; the unit takes the next request
//   while a result waits, and holds its finished next result until m_ready
//   reset: synchronous active low aresetn clears pose, heading and the
//   handshake state and loads the default calibration registers
//   configuration: cfg_we writes register cfg_index (0 meters per count,
//   1 heading per count, 2 yaw rate per count); write only while idle
`include "differential_drive_odometry_unit_assert.svh"
module differential_drive_odometry_unit import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [39:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_left_count,
    input  logic signed [31:0]  s_right_count,
    input  logic [31:0]         s_elapsed_us,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_pos_x,
    output logic signed [63:0]  m_pos_y,
    output logic [31:0]         m_heading_angle,
    output logic signed [31:0]  m_quat_z,
    output logic signed [31:0]  m_quat_w,
    output logic signed [47:0]  m_linear_rate,
    output logic signed [47:0]  m_yaw_rate,
    output logic                m_rate_valid
);

    ctrl_t ctl;
    stat_t st;

    // sequencer
    ddo_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .st, .ctl
    );

    // arithmetic and pose state
    ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk, .aresetn, .ctl, .st,
        .cfg_we, .cfg_idx(cfg_index), .cfg_data,
        .left_count(s_left_count), .right_count(s_right_count),
        .elapsed_us(s_elapsed_us),
        .pos_x(m_pos_x), .pos_y(m_pos_y), .heading_angle(m_heading_angle),
        .quat_z(m_quat_z), .quat_w(m_quat_w),
        .linear_rate(m_linear_rate), .yaw_rate(m_yaw_rate),
        .rate_valid(m_rate_valid)
    );

    // a new request is only taken with no work in flight
    `ODO_ASSERT_IMP(a_one_cmd, aclk, aresetn, ctl.load, !ctl.out_load)
    // a result is raised only by the output load
    `ODO_ASSERT_NXT(a_mv_src, aclk, aresetn, !m_valid && !ctl.out_load, !m_valid)
    // a waiting result stays valid and unchanged
    `ODO_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pos_x))

endmodule

FILE: sv/ddo_ctrl.sv
// controller state machine of the odometry unit
// depends on ddo_pkg
module ddo_ctrl import ddo_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t st,
    output ctrl_t ctl
);

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_COR;
                end
            end
            ST_COR: begin
                ctl.cor_step = 1'b1;
                if (st.cor_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ctl.mul_step = 1'b1;
                if (st.mul_last) begin
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                ctl.pos_upd = 1'b1;
                state_next  = ST_HEAD;
            end
            ST_HEAD: begin
                ctl.head_upd = 1'b1;
                state_next   = ST_COR2;
            end
            ST_COR2: begin
                ctl.cor_step = 1'b1;
                if (st.cor_last) begin
                    ctl.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                if (st.div_last) begin
                    ctl.div_fin  = 1'b1;
                    ctl.div_init = 1'b1;
                    ctl.div_sel  = 1'b1;
                    state_next   = ST_DIV2;
                end
            end
            ST_DIV2: begin
                ctl.div_step = 1'b1;
                ctl.div_sel  = 1'b1;
                if (st.div_last) begin
                    ctl.div_fin = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && s_valid) ctl.cor_init = 1'b1;
        if (state_reg == ST_HEAD) ctl.cor2_init = 1'b1;
    end

endmodule

FILE: sv/ddo_datapath.sv
// datapath of the odometry unit: cordic, serial multiplier, serial divider, pose
// depends on ddo_pkg
module ddo_datapath import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_t               ctl,
    output stat_t               st,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [39:0]         cfg_data,
    input  logic signed [31:0]  left_count,
    input  logic signed [31:0]  right_count,
    input  logic [31:0]         elapsed_us,
    output logic signed [63:0]  pos_x,
    output logic signed [63:0]  pos_y,
    output logic [31:0]         heading_angle,
    output logic signed [31:0]  quat_z,
    output logic signed [31:0]  quat_w,
    output logic signed [47:0]  linear_rate,
    output logic signed [47:0]  yaw_rate,
    output logic                rate_valid
);

    localparam int StepW = $clog2(CORDIC_STEPS + 1);

    // configuration
    logic [39:0] mpc_reg, hpc_reg, ypc_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpc_reg <= MPC_RESET;
            hpc_reg <= HPC_RESET;
            ypc_reg <= YPC_RESET;
        end else if (cfg_we) begin
            if (cfg_idx == REG_MPC) mpc_reg <= cfg_data;
            if (cfg_idx == REG_HPC) hpc_reg <= cfg_data;
            if (cfg_idx == REG_YPC) ypc_reg <= cfg_data;
        end
    end

    // captured request
    logic signed [32:0] sum_reg, diff_reg;
    logic [31:0]        us_reg;
    logic signed [63:0] x_reg, y_reg;
    logic [47:0]        hf_reg;

    // heading step |diff| * hpc mod 2^48, sign applied at the update
    logic [47:0]        hprod_reg;
    logic [47:0]        hf_new;
    assign hf_new = hf_reg + (diff_reg[32] ? -hprod_reg : hprod_reg);

    // cordic
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic [StepW-1:0]   ci_reg;
    logic [31:0]        cang;
    logic [1:0]         quad;
    logic [31:0]        cred;
    logic signed [33:0] dx, dy, cxc, cyc, cosv, sinv;

    // second pass runs on half of the heading being written this cycle
    assign cang = ctl.cor_init ? hf_reg[47:16] : {1'b0, hf_new[47:17]};
    assign quad = cang[31:30];
    assign cred = (quad == 2'd1 || quad == 2'd2) ? cang - 32'h8000_0000 : cang;
    assign dx   = cy_reg >>> ci_reg;
    assign dy   = cx_reg >>> ci_reg;
    assign cxc  = (cx_reg > ONE_Q30) ? ONE_Q30 : (cx_reg < -ONE_Q30) ? -ONE_Q30 : cx_reg;
    assign cyc  = (cy_reg > ONE_Q30) ? ONE_Q30 : (cy_reg < -ONE_Q30) ? -ONE_Q30 : cy_reg;
    assign cosv = flip_reg ? -cxc : cxc;
    assign sinv = flip_reg ? -cyc : cyc;
    assign st.cor_last = (ci_reg == StepW'(CORDIC_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (ctl.cor_init || ctl.cor2_init) begin
            flip_reg <= (quad == 2'd1 || quad == 2'd2);
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= 34'(signed'(cred));
            ci_reg   <= '0;
        end else if (ctl.cor_step) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - 34'(atan_val(5'(ci_reg)));
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + 34'(atan_val(5'(ci_reg)));
            end
            ci_reg <= ci_reg + 1'b1;
        end
    end

    // travel: |sum| * mpc * |t| >> 39
    // step 0 latches the settled cordic and the low half of |sum| * mpc,
    // step 1 adds the high half, steps 2 and 3 build the heading product,
    // steps 2 to 32 shift-add over the 31 bits of |t|
    logic [32:0]  sum_m, diff_m;
    logic [32:0]  ta;
    logic [19:0]  tk;
    logic [52:0]  tprod;
    logic [72:0]  base_reg;
    logic [103:0] accx_reg, accy_reg;
    logic [30:0]  tx_reg, ty_reg;
    logic         nx_reg, ny_reg;
    logic [5:0]   mi_reg;
    assign sum_m  = sum_reg[32] ? 33'(-sum_reg) : 33'(sum_reg);
    assign diff_m = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
    assign ta     = mi_reg[1] ? diff_m : sum_m;
    assign tprod  = ta * tk;
    assign st.mul_last = (mi_reg == 6'd32);

    always_comb begin
        unique case (mi_reg[1:0])
            2'd0: tk = mpc_reg[19:0];
            2'd1: tk = mpc_reg[39:20];
            2'd2: tk = hpc_reg[19:0];
            2'd3: tk = hpc_reg[39:20];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            mi_reg <= '0;
        end else if (ctl.mul_step) begin
            mi_reg <= mi_reg + 1'b1;
            if (mi_reg == 6'd0) begin
                accx_reg <= '0;
                accy_reg <= '0;
                tx_reg   <= 31'(cosv[33] ? -cosv : cosv);
                ty_reg   <= 31'(sinv[33] ? -sinv : sinv);
                nx_reg   <= sum_reg[32] ^ cosv[33];
                ny_reg   <= sum_reg[32] ^ sinv[33];
                base_reg <= 73'(tprod);
            end else begin
                if (mi_reg == 6'd1) base_reg <= base_reg + {tprod, 20'd0};
                if (mi_reg == 6'd2) hprod_reg <= tprod[47:0];
                if (mi_reg == 6'd3) hprod_reg <= hprod_reg + {tprod[27:0], 20'd0};
                if (mi_reg >= 6'd2) begin
                    accx_reg <= (accx_reg << 1) + (tx_reg[30] ? 104'(base_reg) : '0);
                    accy_reg <= (accy_reg << 1) + (ty_reg[30] ? 104'(base_reg) : '0);
                    tx_reg   <= tx_reg << 1;
                    ty_reg   <= ty_reg << 1;
                end
            end
        end
    end

    function automatic logic signed [63:0] to_delta(input logic [103:0] acc,
                                                    input logic neg);
        logic [64:0] mag;
        mag = (acc[103:103] != 0 || acc[102:39] > 64'h7FFF_FFFF_FFFF_FFFF)
            ? 65'h0_8000_0000_0000_0000 : {1'b0, acc[102:39]};
        if (neg) return 64'(-mag);
        return (mag[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : mag[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
        return s[63:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg  <= '0;
            y_reg  <= '0;
            hf_reg <= '0;
        end else begin
            if (ctl.pos_upd) begin
                x_reg <= sat_add(x_reg, to_delta(accx_reg, nx_reg));
                y_reg <= sat_add(y_reg, to_delta(accy_reg, ny_reg));
            end
            if (ctl.head_upd) hf_reg <= hf_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            sum_reg  <= 33'(left_count) + 33'(right_count);
            diff_reg <= 33'(right_count) - 33'(left_count);
            us_reg   <= elapsed_us;
        end
    end

    // rate divider: steps 0 and 1 build |m| * k from 20-bit halves, steps 2 to 6
    // scale it by 10^6, steps 7 to 126 restore one quotient bit each, step 127 idles
    localparam logic [6:0] DivLast = 7'd127;
    logic [119:0] dvd_reg;
    logic [40:0]  d_reg;
    logic [41:0]  rem_reg;
    logic [47:0]  q_reg;
    logic         ov_reg, dn_reg;
    logic [6:0]   di_reg;
    logic [41:0]  rsh;
    logic [72:0]  mk_reg;
    logic [32:0]  mm;
    logic [39:0]  kk;
    logic [19:0]  rk;
    logic [52:0]  rprod;
    assign mm    = ctl.div_sel ? diff_m : sum_m;
    assign kk    = ctl.div_sel ? ypc_reg : mpc_reg;
    assign rk    = (di_reg == 7'd0) ? kk[19:0] : kk[39:20];
    assign rprod = mm * rk;
    assign rsh   = {rem_reg[40:0], dvd_reg[119]};
    assign st.div_last = (di_reg == DivLast);
    assign st.us_zero  = (us_reg == '0);

    logic signed [47:0] lin_reg, yaw_reg;
    logic [47:0]        rres;
    assign rres = (ov_reg || q_reg[47]) ? (dn_reg ? 48'h8000_0000_0000 : RATE_MAX)
                : (dn_reg ? 48'(-q_reg) : q_reg);

    always_ff @(posedge aclk) begin
        if (ctl.div_fin) begin
            if (ctl.div_sel && !ctl.div_init) yaw_reg <= st.us_zero ? '0 : rres;
            else lin_reg <= st.us_zero ? '0 : rres;
        end
        if (ctl.div_init) begin
            d_reg   <= ctl.div_sel ? {1'b0, us_reg, 8'd0} : {us_reg, 9'd0};
            dn_reg  <= ctl.div_sel ? diff_reg[32] : sum_reg[32];
            rem_reg <= '0;
            q_reg   <= '0;
            ov_reg  <= 1'b0;
            di_reg  <= '0;
        end else if (ctl.div_step) begin
            di_reg <= di_reg + 1'b1;
            unique case (di_reg)
                7'd0: mk_reg <= 73'(rprod);
                7'd1: mk_reg <= mk_reg + {rprod, 20'd0};
                // 10^6 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6
                7'd2: dvd_reg <= 120'(mk_reg) << 20;
                7'd3: dvd_reg <= dvd_reg - (120'(mk_reg) << 16);
                7'd4: dvd_reg <= dvd_reg + (120'(mk_reg) << 14);
                7'd5: dvd_reg <= dvd_reg + (120'(mk_reg) << 9);
                7'd6: dvd_reg <= dvd_reg + (120'(mk_reg) << 6);
                DivLast: begin
                end
                default: begin
                    if (q_reg[47]) ov_reg <= 1'b1;
                    if (rsh >= 42'(d_reg)) begin
                        rem_reg <= rsh - 42'(d_reg);
                        q_reg   <= {q_reg[46:0], 1'b1};
                    end else begin
                        rem_reg <= rsh;
                        q_reg   <= {q_reg[46:0], 1'b0};
                    end
                    dvd_reg <= dvd_reg << 1;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            pos_x         <= x_reg;
            pos_y         <= y_reg;
            heading_angle <= hf_reg[47:16];
            quat_z        <= 32'(sinv);
            quat_w        <= 32'(cosv);
            linear_rate   <= lin_reg;
            yaw_rate      <= yaw_reg;
            rate_valid    <= !st.us_zero;
        end
    end

endmodule
